// ===== rtl/core/srdf_pkg.sv =====
// Shared constants for the damped spring force pipeline.
package srdf_pkg;

    localparam int UNIT_BITS = 30;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROPE_MODE   = 2'd3;

    localparam logic [31:0] DAMPING_RESET = 32'd5242880;

endpackage

// ===== rtl/core/srdf_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module srdf_isqrt #(
    parameter int RW = 33
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_rad,
    output logic [RW-1:0]   o_root
);
    logic [RW+1:0]   r_rem  [0:RW-1];
    logic [RW-1:0]   r_q    [0:RW-1];
    logic [2*RW-1:0] r_n    [0:RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0]   w_rem;
        logic [RW-1:0]   w_q;
        logic [2*RW-1:0] w_n;
        logic [RW+3:0]   w_r2;
        logic [RW+3:0]   w_trial;
        logic            w_ge;

        if (k == 0) begin : g_first
            assign w_rem = '0;
            assign w_q   = '0;
            assign w_n   = i_rad;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_q   = r_q[k-1];
            assign w_n   = r_n[k-1];
        end

        assign w_r2    = {w_rem, w_n[2*RW-1:2*RW-2]};
        assign w_trial = {2'b00, w_q, 2'b01};
        assign w_ge    = w_r2 >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? (RW+2)'(w_r2 - w_trial) : (RW+2)'(w_r2);
                r_q[k]   <= {w_q[RW-2:0], w_ge};
                r_n[k]   <= {w_n[2*RW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_q[RW-1];

endmodule

// ===== rtl/core/srdf_udiv.sv =====
// Pipelined fraction divider: floor(num * 2^UNIT_BITS / den) for num <= den.
module srdf_udiv #(
    parameter int NW = 33
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [NW-1:0]                 i_num,
    input  logic [NW-1:0]                 i_den,
    output logic [srdf_pkg::UNIT_BITS:0]  o_quo
);
    import srdf_pkg::*;

    localparam int QW = UNIT_BITS + 1;

    logic [NW-1:0] r_rem [0:QW-1];
    logic [NW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NW:0]   w_r;
        logic [NW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_r   = {1'b0, i_num};
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_r   = {r_rem[k-1], 1'b0};
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
        end

        assign w_ge = w_r >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? NW'(w_r - {1'b0, w_den}) : NW'(w_r);
                r_den[k] <= w_den;
                r_quo[k] <= {w_quo[QW-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== rtl/core/spring_rope_damper_force.sv =====
// Damped spring / rope force between two 2D bodies, fully pipelined.
//
//  channel   direction  handshake          word
//  input     in         i_valid / o_stall  positions and velocities of A and B
//  output    out        o_valid / i_stall  forces on A and B, engaged flag
//  config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One word enters per cycle unless the output stalls; the pipeline depth is set by the
// one-bit-per-stage square root and the 31-stage unit divider.
// A stalled output word freezes the whole pipeline; nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and config, damping to DAMPING_RESET.
module spring_rope_damper_force #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [WORD_WIDTH-1:0]   i_a_pos_x,
    input  logic signed [WORD_WIDTH-1:0]   i_a_pos_y,
    input  logic signed [WORD_WIDTH-1:0]   i_b_pos_x,
    input  logic signed [WORD_WIDTH-1:0]   i_b_pos_y,
    input  logic signed [WORD_WIDTH-1:0]   i_a_vel_x,
    input  logic signed [WORD_WIDTH-1:0]   i_a_vel_y,
    input  logic signed [WORD_WIDTH-1:0]   i_b_vel_x,
    input  logic signed [WORD_WIDTH-1:0]   i_b_vel_y,
    input  logic                           i_cfg_we,
    input  logic [srdf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_WIDTH-1:0]          i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [WORD_WIDTH-1:0]   o_a_force_x,
    output logic signed [WORD_WIDTH-1:0]   o_a_force_y,
    output logic signed [WORD_WIDTH-1:0]   o_b_force_x,
    output logic signed [WORD_WIDTH-1:0]   o_b_force_y,
    output logic                           o_engaged
);
    import srdf_pkg::*;

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int MW  = W + 1;
    localparam int RW  = MW;
    localparam int SQW = 2 * MW;
    localparam int UW  = UNIT_BITS + 1;
    localparam int EW  = W + 1;
    localparam int PW  = MW + UW;
    localparam int DTW = PW + 1 - UNIT_BITS;
    localparam int SPW = W + EW;
    localparam int SPS = SPW - F;
    localparam int DPW = W + DTW;
    localparam int DPS = DPW - F;
    localparam int FW  = DPS + 1;
    localparam int GW  = FW + UW;
    localparam int OW  = GW - UNIT_BITS;
    localparam int EL  = EW / 2;
    localparam int EH  = EW - EL;
    localparam int DL  = DTW / 2;
    localparam int DH  = DTW - DL;
    localparam int FL  = FW / 2;
    localparam int FH  = FW - FL;
    localparam int LAT = 3 + RW + 1 + UW + 7;

    localparam logic [OW-1:0] LIM_NEG = OW'({1'b1, {(W-1){1'b0}}});
    localparam logic [OW-1:0] LIM_POS = LIM_NEG - OW'(1);

    typedef struct packed {
        logic          dxneg;
        logic          dyneg;
        logic          rxneg;
        logic          ryneg;
        logic [MW-1:0] arx;
        logic [MW-1:0] ary;
        logic [MW-1:0] mdx;
        logic [MW-1:0] mdy;
        logic          ext_neg;
        logic [EW-1:0] ext_m;
        logic          engaged;
        logic          zero;
        logic          dot_neg;
        logic [UW-1:0] ux;
        logic [UW-1:0] uy;
    } t_pay;

    function automatic logic [MW-1:0] abs_mw(input logic signed [MW-1:0] v);
        return v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    function automatic logic [W-1:0] sat(input logic [OW-1:0] m, input logic neg);
        logic [OW-1:0] lim;
        logic [OW-1:0] v;
        lim = neg ? LIM_NEG : LIM_POS;
        v   = (m > lim) ? lim : m;
        return neg ? W'(OW'(0) - v) : W'(v);
    endfunction

    // configuration
    logic [W-1:0] r_rest;
    logic [W-1:0] r_stiff;
    logic [W-1:0] r_damp;
    logic         r_rope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest  <= '0;
            r_stiff <= '0;
            r_damp  <= W'(DAMPING_RESET);
            r_rope  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REST_LENGTH: r_rest  <= i_cfg_data;
                CFG_STIFFNESS:   r_stiff <= i_cfg_data;
                CFG_DAMPING:     r_damp  <= i_cfg_data;
                CFG_ROPE_MODE:   r_rope  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // valid bits
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign o_stall = r_vld[LAT-1] && i_stall;
    assign w_en    = !o_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // stage A: differences
    logic signed [MW-1:0] r_dx, r_dy, r_rx, r_ry;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= MW'(i_a_pos_x) - MW'(i_b_pos_x);
            r_dy <= MW'(i_a_pos_y) - MW'(i_b_pos_y);
            r_rx <= MW'(i_a_vel_x) - MW'(i_b_vel_x);
            r_ry <= MW'(i_a_vel_y) - MW'(i_b_vel_y);
        end
    end

    // stage B: magnitudes and squares
    t_pay           n_pb;
    t_pay           r_pb;
    logic [SQW-1:0] r_sqx, r_sqy;

    always_comb begin
        n_pb       = '0;
        n_pb.dxneg = r_dx[MW-1];
        n_pb.dyneg = r_dy[MW-1];
        n_pb.rxneg = r_rx[MW-1];
        n_pb.ryneg = r_ry[MW-1];
        n_pb.arx   = abs_mw(r_rx);
        n_pb.ary   = abs_mw(r_ry);
        n_pb.mdx   = abs_mw(r_dx);
        n_pb.mdy   = abs_mw(r_dy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pb  <= n_pb;
            r_sqx <= SQW'(n_pb.mdx) * SQW'(n_pb.mdx);
            r_sqy <= SQW'(n_pb.mdy) * SQW'(n_pb.mdy);
        end
    end

    // stage C: radicand
    t_pay           r_pc;
    logic [SQW-1:0] r_rad;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc  <= r_pb;
            r_rad <= r_sqx + r_sqy;
        end
    end

    logic [RW-1:0] w_root;

    srdf_isqrt #(.RW(RW)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    t_pay r_ps [0:RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_sq_dly
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ps[k] <= (k == 0) ? r_pc : r_ps[(k == 0) ? 0 : k-1];
            end
        end
    end

    // stage D: extension, rope test, divider operands
    t_pay          n_pd;
    t_pay          r_pd;
    logic [MW-1:0] r_den;

    always_comb begin
        n_pd         = r_ps[RW-1];
        n_pd.ext_neg = {1'b0, r_rest} > w_root;
        n_pd.ext_m   = n_pd.ext_neg ? EW'({1'b0, r_rest} - w_root)
                                    : EW'(w_root - {1'b0, r_rest});
        n_pd.engaged = !(r_rope && (n_pd.ext_neg || (n_pd.ext_m == '0)));
        n_pd.zero    = !n_pd.engaged || (w_root == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd  <= n_pd;
            r_den <= w_root;
        end
    end

    logic [UW-1:0] w_ux, w_uy;

    srdf_udiv #(.NW(MW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_pd.mdx),
        .i_den (r_den),
        .o_quo (w_ux)
    );

    srdf_udiv #(.NW(MW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_pd.mdy),
        .i_den (r_den),
        .o_quo (w_uy)
    );

    t_pay r_pv [0:UW-1];

    for (genvar k = 0; k < UW; k++) begin : g_div_dly
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pv[k] <= (k == 0) ? r_pd : r_pv[(k == 0) ? 0 : k-1];
            end
        end
    end

    // stage E: velocity projections
    t_pay          n_pe;
    t_pay          r_pe;
    logic [PW-1:0] r_px, r_py;

    always_comb begin
        n_pe    = r_pv[UW-1];
        n_pe.ux = w_ux;
        n_pe.uy = w_uy;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pe <= n_pe;
            r_px <= PW'(n_pe.arx) * PW'(w_ux);
            r_py <= PW'(n_pe.ary) * PW'(w_uy);
        end
    end

    // stage F: dot product, spring partials
    t_pay                  n_pf;
    t_pay                  r_pf;
    logic signed [PW+1:0]  n_pxs, n_pys, n_dsum;
    logic [PW+1:0]         n_dabs;
    logic [DTW-1:0]        r_dot;
    logic [W+EL-1:0]       r_splo;
    logic [W+EH-1:0]       r_sphi;

    always_comb begin
        n_pxs  = (r_pe.rxneg != r_pe.dxneg) ? -$signed({2'b00, r_px})
                                            : $signed({2'b00, r_px});
        n_pys  = (r_pe.ryneg != r_pe.dyneg) ? -$signed({2'b00, r_py})
                                            : $signed({2'b00, r_py});
        n_dsum = n_pxs + n_pys;
        n_dabs = n_dsum[PW+1] ? $unsigned(-n_dsum) : $unsigned(n_dsum);
        n_pf         = r_pe;
        n_pf.dot_neg = n_dsum[PW+1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pf   <= n_pf;
            r_dot  <= DTW'(n_dabs >> UNIT_BITS);
            r_splo <= (W+EL)'(r_stiff) * (W+EL)'(r_pe.ext_m[EL-1:0]);
            r_sphi <= (W+EH)'(r_stiff) * (W+EH)'(r_pe.ext_m[EW-1:EL]);
        end
    end

    // stage G: spring term, damping partials
    t_pay            r_pg;
    logic [SPS-1:0]  r_spr_g;
    logic [W+DL-1:0] r_dplo;
    logic [W+DH-1:0] r_dphi;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pg    <= r_pf;
            r_spr_g <= SPS'(((SPW'(r_sphi) << EL) + SPW'(r_splo)) >> F);
            r_dplo  <= (W+DL)'(r_damp) * (W+DL)'(r_dot[DL-1:0]);
            r_dphi  <= (W+DH)'(r_damp) * (W+DH)'(r_dot[DTW-1:DL]);
        end
    end

    // stage H: damping term
    t_pay           r_ph;
    logic [SPS-1:0] r_spr_h;
    logic [DPS-1:0] r_dmp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ph    <= r_pg;
            r_spr_h <= r_spr_g;
            r_dmp   <= DPS'(((DPW'(r_dphi) << DL) + DPW'(r_dplo)) >> F);
        end
    end

    // stage I: scalar force
    t_pay                 r_pi;
    logic signed [FW:0]   n_fs, n_fsp, n_fdm;
    logic [FW-1:0]        r_fm;
    logic                 r_fneg_i;

    always_comb begin
        n_fsp = $signed((FW+1)'(r_spr_h));
        n_fdm = $signed((FW+1)'(r_dmp));
        n_fs  = (r_ph.ext_neg ? -n_fsp : n_fsp) + (r_ph.dot_neg ? -n_fdm : n_fdm);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pi     <= r_ph;
            r_fm     <= n_fs[FW] ? FW'($unsigned(-n_fs)) : FW'($unsigned(n_fs));
            r_fneg_i <= n_fs[FW];
        end
    end

    // stage J: force component partials
    t_pay             r_pj;
    logic             r_fneg_j;
    logic [FL+UW-1:0] r_fxlo, r_fylo;
    logic [FH+UW-1:0] r_fxhi, r_fyhi;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pj     <= r_pi;
            r_fneg_j <= r_fneg_i;
            r_fxlo   <= (FL+UW)'(r_fm[FL-1:0]) * (FL+UW)'(r_pi.ux);
            r_fxhi   <= (FH+UW)'(r_fm[FW-1:FL]) * (FH+UW)'(r_pi.ux);
            r_fylo   <= (FL+UW)'(r_fm[FL-1:0]) * (FL+UW)'(r_pi.uy);
            r_fyhi   <= (FH+UW)'(r_fm[FW-1:FL]) * (FH+UW)'(r_pi.uy);
        end
    end

    // stage K: combine, saturate, output word
    logic [OW-1:0] n_fx, n_fy;
    logic          n_axneg, n_ayneg;

    always_comb begin
        n_fx    = OW'(((GW'(r_fxhi) << FL) + GW'(r_fxlo)) >> UNIT_BITS);
        n_fy    = OW'(((GW'(r_fyhi) << FL) + GW'(r_fylo)) >> UNIT_BITS);
        n_axneg = r_fneg_j == r_pj.dxneg;
        n_ayneg = r_fneg_j == r_pj.dyneg;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_engaged <= r_pj.engaged;
            if (r_pj.zero) begin
                o_a_force_x <= '0;
                o_a_force_y <= '0;
                o_b_force_x <= '0;
                o_b_force_y <= '0;
            end else begin
                o_a_force_x <= sat(n_fx, n_axneg);
                o_a_force_y <= sat(n_fy, n_ayneg);
                o_b_force_x <= sat(n_fx, !n_axneg);
                o_b_force_y <= sat(n_fy, !n_ayneg);
            end
        end
    end

`ifndef SYNTH
    a_slack_no_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_engaged |-> o_a_force_x == '0 && o_a_force_y == '0
                                  && o_b_force_x == '0 && o_b_force_y == '0)
        else $error("force on a slack rope");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word waiting");

    a_reset_empties: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output word valid straight after reset");
`endif

endmodule

// ===== bench/spring_rope_damper_force_test.sv =====
// Self-checking testbench for the damped spring / rope force pipeline.
`timescale 1ns / 100ps

module spring_rope_damper_force_test;
    import srdf_pkg::*;

    localparam int W = 32;
    localparam int FB = 16;
    localparam int UB = 30;
    localparam int LATENCY = W + 43;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 800;

    typedef struct packed {
        logic signed [W-1:0] apx, apy, bpx, bpy, avx, avy, bvx, bvy;
    } t_bodies;

    typedef struct packed {
        logic signed [W-1:0] afx, afy, bfx, bfy;
        logic                eng;
    } t_forces;

    typedef struct {
        t_bodies b;
        logic    typed;
        t_forces f;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_bodies drv = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_REST_LENGTH;
    logic [W-1:0] i_cfg_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_forces got;

    logic [W-1:0] rest_len_r, stiff_r, damp_r;
    logic         rope_r;

    t_forces expected_forces[$];
    int errors = 0;
    int cycles = 0;
    int words_out = 0;
    int engaged_seen = 0;
    int stall_left = 0;
    logic rx_quiet = 1'b0;

    always #2 i_clk = ~i_clk;

    spring_rope_damper_force #(.WORD_WIDTH(W), .FRAC_BITS(FB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_a_pos_x(drv.apx), .i_a_pos_y(drv.apy), .i_b_pos_x(drv.bpx),
        .i_b_pos_y(drv.bpy), .i_a_vel_x(drv.avx), .i_a_vel_y(drv.avy),
        .i_b_vel_x(drv.bvx), .i_b_vel_y(drv.bvy), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_valid(o_valid),
        .i_stall(i_stall), .o_a_force_x(got.afx), .o_a_force_y(got.afy),
        .o_b_force_x(got.bfx), .o_b_force_y(got.bfy), .o_engaged(got.eng)
    );

    function automatic logic [W-1:0] sat(logic [127:0] m, logic neg);
        logic [127:0] lim;
        logic [127:0] v;
        lim = (128'd1 << (W - 1)) - (neg ? 128'd0 : 128'd1);
        v = (m > lim) ? lim : m;
        return neg ? W'(-v) : W'(v);
    endfunction

    function automatic t_forces spring_force(t_bodies b);
        t_forces r;
        logic signed [W:0] dx, dy, rx, ry;
        logic [W:0] mdx, mdy, mrx, mry;
        logic [127:0] sq, t2, mag, ux, uy, px, py, dotm, ext, sp, dp, fm, fx, fy;
        logic ext_neg, px_neg, py_neg, dot_neg, f_neg, sx, sy;
        r = '0;
        dx = $signed(b.apx) - $signed(b.bpx);
        dy = $signed(b.apy) - $signed(b.bpy);
        rx = $signed(b.avx) - $signed(b.bvx);
        ry = $signed(b.avy) - $signed(b.bvy);
        mdx = dx < 0 ? -dx : dx;
        mdy = dy < 0 ? -dy : dy;
        mrx = rx < 0 ? -rx : rx;
        mry = ry < 0 ? -ry : ry;
        sq = 128'(mdx) * 128'(mdx) + 128'(mdy) * 128'(mdy);
        mag = 0;
        for (int k = 63; k >= 0; k--) begin
            t2 = mag | (128'd1 << k);
            if (t2 * t2 <= sq) mag = t2;
        end
        ext_neg = 128'(rest_len_r) > mag;
        ext = ext_neg ? 128'(rest_len_r) - mag : mag - 128'(rest_len_r);
        if (rope_r && (ext_neg || ext == 0)) return r;
        r.eng = 1'b1;
        if (mag == 0) return r;
        ux = (128'(mdx) << UB) / mag;
        uy = (128'(mdy) << UB) / mag;
        px_neg = (rx < 0) != (dx < 0);
        py_neg = (ry < 0) != (dy < 0);
        px = 128'(mrx) * ux;
        py = 128'(mry) * uy;
        if (px_neg == py_neg) begin
            dot_neg = px_neg; dotm = px + py;
        end else if (px >= py) begin
            dot_neg = px_neg; dotm = px - py;
        end else begin
            dot_neg = py_neg; dotm = py - px;
        end
        dotm = dotm >> UB;
        sp = (128'(stiff_r) * ext) >> FB;
        dp = (128'(damp_r) * dotm[63:0]) >> FB;
        if (ext_neg == dot_neg) begin
            f_neg = ext_neg; fm = sp + dp;
        end else if (sp >= dp) begin
            f_neg = ext_neg; fm = sp - dp;
        end else begin
            f_neg = dot_neg; fm = dp - sp;
        end
        fx = (fm * ux) >> UB;
        fy = (fm * uy) >> UB;
        sx = f_neg != (dx < 0);
        sy = f_neg != (dy < 0);
        r.afx = sat(fx, !sx);
        r.afy = sat(fy, !sy);
        r.bfx = sat(fx, sx);
        r.bfy = sat(fy, sy);
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_REST_LENGTH: rest_len_r = val;
            CFG_STIFFNESS:   stiff_r = val;
            CFG_DAMPING:     damp_r = val;
            CFG_ROPE_MODE:   rope_r = val[0];
            default: ;
        endcase
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(t_bodies b, t_forces exp_f);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        drv <= b;
        expected_forces = {expected_forces, exp_f};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_forces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [W-1:0] rnd_coord(int span);
        logic [W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = {{(W - 16){1'b0}}, 16'($urandom)} << $urandom_range(span);
            default: v = W'($signed($urandom_range(4000)) - 2000) <<< 12;
        endcase
        return $urandom_range(1) ? v : -v;
    endfunction

    function automatic t_bodies rnd_bodies();
        t_bodies b;
        b.apx = rnd_coord(15); b.apy = rnd_coord(15);
        b.avx = rnd_coord(15); b.avy = rnd_coord(15);
        b.bvx = rnd_coord(15); b.bvy = rnd_coord(15);
        case ($urandom_range(9))
            0: begin b.bpx = b.apx; b.bpy = b.apy; end
            1: begin b.bpx = b.apx + rnd_coord(4); b.bpy = b.apy; end
            2, 3: begin
                b.bpx = b.apx + $signed(W'($urandom_range(2 * 65536 * 40))) - 65536 * 40;
                b.bpy = b.apy + $signed(W'($urandom_range(2 * 65536 * 40))) - 65536 * 40;
            end
            default: begin b.bpx = rnd_coord(15); b.bpy = rnd_coord(15); end
        endcase
        return b;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_quiet) begin
                i_stall <= 1'b0;
                stall_left <= 0;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(99) < 80) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b1;
                stall_left <= gap_len();
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_forces.size() == 0) begin
                $error("unexpected output word");
                errors++;
            end else begin
                t_forces e;
                e = expected_forces.pop_front();
                words_out++;
                if (got.eng) engaged_seen++;
                if (got.afx !== e.afx) begin
                    $error("a_force_x exp %h got %h", e.afx, got.afx); errors++;
                end
                if (got.afy !== e.afy) begin
                    $error("a_force_y exp %h got %h", e.afy, got.afy); errors++;
                end
                if (got.bfx !== e.bfx) begin
                    $error("b_force_x exp %h got %h", e.bfx, got.bfx); errors++;
                end
                if (got.bfy !== e.bfy) begin
                    $error("b_force_y exp %h got %h", e.bfy, got.bfy); errors++;
                end
                if (got.eng !== e.eng) begin
                    $error("engaged exp %b got %b", e.eng, got.eng); errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row rw;
        t_forces zf, ez;
        localparam logic [W-1:0] MAXP = {1'b0, {(W - 1){1'b1}}};
        localparam logic [W-1:0] MINN = {1'b1, {(W - 1){1'b0}}};
        localparam logic [W-1:0] ONE = W'(1) << FB;
        rest_len_r = '0; stiff_r = '0; damp_r = DAMPING_RESET; rope_r = 1'b0;
        zf = '0;
        ez = '0; ez.eng = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: zero separation gives no force, engaged in spring mode; other rows use spring_force
        rw.typed = 1; rw.f = ez;
        rw.b = '0; rows = {rows, rw};
        rw.b = {8{MAXP}}; rows = {rows, rw};
        rw.b = {8{MINN}}; rows = {rows, rw};
        rw.typed = 0;
        rw.b = {MAXP, MAXP, MINN, MINN, MAXP, MAXP, MINN, MINN}; rows = {rows, rw};
        rw.b = {MINN, MINN, MAXP, MAXP, MINN, MINN, MAXP, MAXP}; rows = {rows, rw};
        rw.b = {ONE, W'(0), W'(0), W'(0), ONE, W'(0), W'(0), W'(0)}; rows = {rows, rw};
        rw.b = {W'(0), -ONE, W'(0), W'(0), W'(0), ONE, W'(0), W'(0)}; rows = {rows, rw};
        rw.b = {W'(3) << FB, W'(4) << FB, W'(0), W'(0), W'(0), W'(0), ONE, -ONE};
        rows = {rows, rw};
        rw.b = {W'(1), W'(1), W'(0), W'(0), MAXP, MINN, MINN, MAXP}; rows = {rows, rw};
        foreach (rows[i]) send(rows[i].b, rows[i].typed ? rows[i].f : spring_force(rows[i].b));
        drain();

        // phases: spring, rope, rope extremes, unstalled spring, random, rope with no stiffness
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_REST_LENGTH, W'(10) << FB);
                    write_reg(CFG_STIFFNESS, W'(50) << FB);
                    write_reg(CFG_DAMPING, W'(2) << FB);
                    write_reg(CFG_ROPE_MODE, W'(0));
                end
                1: write_reg(CFG_ROPE_MODE, W'(1));
                2: begin
                    write_reg(CFG_REST_LENGTH, '1);
                    write_reg(CFG_STIFFNESS, '1);
                    write_reg(CFG_DAMPING, '1);
                end
                3: begin
                    write_reg(CFG_ROPE_MODE, W'(0));
                    write_reg(CFG_REST_LENGTH, '0);
                    write_reg(CFG_DAMPING, '0);
                end
                4: begin
                    write_reg(CFG_REST_LENGTH, $urandom);
                    write_reg(CFG_STIFFNESS, $urandom);
                    write_reg(CFG_DAMPING, $urandom);
                    write_reg(CFG_ROPE_MODE, W'($urandom_range(1)));
                end
                default: begin
                    write_reg(CFG_REST_LENGTH, W'($urandom_range(30)) << FB);
                    write_reg(CFG_STIFFNESS, '0);
                    write_reg(CFG_DAMPING, $urandom);
                    write_reg(CFG_ROPE_MODE, W'(1));
                end
            endcase
            if (ph == 1) begin
                rw.b = '0;
                send(rw.b, zf);
            end
            rx_quiet = (ph == 3);
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                t_bodies b;
                b = rnd_bodies();
                send(b, spring_force(b));
            end
            rx_quiet = 1'b0;
            drain();
        end

        $display("Covered %0d output words (%0d engaged) over spring and rope settings.",
                 words_out, engaged_seen);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== spring_rope_damper_force.f =====
rtl/core/srdf_pkg.sv
rtl/core/srdf_isqrt.sv
rtl/core/srdf_udiv.sv
rtl/core/spring_rope_damper_force.sv
bench/spring_rope_damper_force_test.sv
